[hw/rtl/pje_pkg.sv]
// ----------------------------------------------------------------------------
// pje_pkg
// shared constants, command and status types of the prismatic joint energy unit
// ----------------------------------------------------------------------------
package pje_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int CHUNK_W         = 2;

    // input slot codes
    localparam logic [3:0] SLOT_FRAME_A_FIRST = 4'd0;
    localparam logic [3:0] SLOT_FRAME_A_LAST  = 4'd3;
    localparam logic [3:0] SLOT_FRAME_B_FIRST = 4'd4;
    localparam logic [3:0] SLOT_FRAME_B_LAST  = 4'd7;
    localparam logic [3:0] SLOT_ANCHOR_A      = 4'd8;
    localparam logic [3:0] SLOT_ANCHOR_B      = 4'd9;
    localparam logic [3:0] SLOT_AXIS          = 4'd10;
    localparam logic [3:0] SLOT_STIFF         = 4'd11;

    localparam logic [62:0] MAX63 = {63{1'b1}};

    // multiplier operand selection
    typedef enum logic [2:0] {
        MOP_NONE,
        MOP_MAP,
        MOP_AXD,
        MOP_AXP,
        MOP_RSQ,
        MOP_DSQ,
        MOP_KPOS,
        MOP_KROT
    } t_mop;

    typedef struct packed {
        t_mop               op;
        logic               body;
        logic [1:0]         row;
        logic [1:0]         comp;
        logic [CHUNK_W-1:0] chunk;
        logic               first;
        logic               last;
        logic               load;
        logic               start;
        logic               fin1;
        logic               fin2;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

[hw/rtl/pje_ctrl.sv]
// ----------------------------------------------------------------------------
// pje_ctrl
// sequencer that steps the shared multiplier through one joint evaluation
// ----------------------------------------------------------------------------
module pje_ctrl #(
    parameter int COORD_WIDTH = pje_pkg::COORD_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    input  logic             i_s_axis_tlast,
    output logic             o_s_axis_tready,
    input  pje_pkg::t_status i_status,
    output pje_pkg::t_cmd    o_cmd
);

    localparam int SQW = 2 * COORD_WIDTH + 4;
    localparam int NCH = (SQW + COORD_WIDTH) / (COORD_WIDTH + 1);
    localparam logic [pje_pkg::CHUNK_W-1:0] CHUNK_TOP = pje_pkg::CHUNK_W'(NCH - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MAP, ST_AXD, ST_GAP, ST_AXP, ST_RSQ, ST_DSQ,
        ST_KPOS, ST_KROT, ST_DRAIN, ST_FIN1, ST_FIN2
    } t_state;

    t_state                      r_state;
    logic                        r_body;
    logic [1:0]                  r_row;
    logic [1:0]                  r_comp;
    logic [pje_pkg::CHUNK_W-1:0] r_chunk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_body  <= 1'b0;
            r_row   <= 2'd0;
            r_comp  <= 2'd0;
            r_chunk <= CHUNK_TOP;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid && i_s_axis_tlast) begin
                        r_state <= ST_MAP;
                        r_body  <= 1'b0;
                        r_row   <= 2'd0;
                        r_comp  <= 2'd0;
                    end
                end
                ST_MAP: begin
                    r_row <= r_row + 2'd1;
                    if (r_row == 2'd3) begin
                        r_comp <= (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
                        if (r_comp == 2'd2) begin
                            r_body <= 1'b1;
                            if (r_body) r_state <= ST_AXD;
                        end
                    end
                end
                ST_AXD: begin
                    r_comp <= (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
                    if (r_comp == 2'd2) r_state <= ST_GAP;
                end
                ST_GAP: begin
                    r_state <= ST_AXP;
                end
                ST_AXP: begin
                    r_comp <= (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
                    if (r_comp == 2'd2) r_state <= ST_RSQ;
                end
                ST_RSQ: begin
                    r_comp <= (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
                    if (r_comp == 2'd2) begin
                        r_state <= ST_DSQ;
                        r_row   <= 2'd1;
                    end
                end
                ST_DSQ: begin
                    r_comp <= (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
                    if (r_comp == 2'd2) begin
                        r_row <= r_row + 2'd1;
                        if (r_row == 2'd3) begin
                            r_state <= ST_KPOS;
                            r_chunk <= CHUNK_TOP;
                        end
                    end
                end
                ST_KPOS: begin
                    r_chunk <= (r_chunk == '0) ? CHUNK_TOP : r_chunk - 1'b1;
                    if (r_chunk == '0) r_state <= ST_KROT;
                end
                ST_KROT: begin
                    r_chunk <= (r_chunk == '0) ? CHUNK_TOP : r_chunk - 1'b1;
                    if (r_chunk == '0) r_state <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    r_state <= ST_FIN1;
                end
                ST_FIN1: begin
                    r_state <= ST_FIN2;
                end
                ST_FIN2: begin
                    if (i_status.out_free) r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd       = '0;
        o_cmd.op    = pje_pkg::MOP_NONE;
        o_cmd.body  = r_body;
        o_cmd.row   = r_row;
        o_cmd.comp  = r_comp;
        o_cmd.chunk = r_chunk;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load  = i_s_axis_tvalid;
                o_cmd.start = i_s_axis_tvalid && i_s_axis_tlast;
            end
            ST_MAP: begin
                o_cmd.op    = pje_pkg::MOP_MAP;
                o_cmd.first = (r_row == 2'd0);
                o_cmd.last  = (r_row == 2'd3);
            end
            ST_AXD: begin
                o_cmd.op    = pje_pkg::MOP_AXD;
                o_cmd.first = (r_comp == 2'd0);
                o_cmd.last  = (r_comp == 2'd2);
            end
            ST_AXP: begin
                o_cmd.op    = pje_pkg::MOP_AXP;
                o_cmd.first = 1'b1;
                o_cmd.last  = 1'b1;
            end
            ST_RSQ: begin
                o_cmd.op    = pje_pkg::MOP_RSQ;
                o_cmd.first = (r_comp == 2'd0);
                o_cmd.last  = (r_comp == 2'd2);
            end
            ST_DSQ: begin
                o_cmd.op    = pje_pkg::MOP_DSQ;
                o_cmd.first = (r_row == 2'd1) && (r_comp == 2'd0);
                o_cmd.last  = (r_row == 2'd3) && (r_comp == 2'd2);
            end
            ST_KPOS: begin
                o_cmd.op    = pje_pkg::MOP_KPOS;
                o_cmd.first = (r_chunk == CHUNK_TOP);
                o_cmd.last  = (r_chunk == '0);
            end
            ST_KROT: begin
                o_cmd.op    = pje_pkg::MOP_KROT;
                o_cmd.first = (r_chunk == CHUNK_TOP);
                o_cmd.last  = (r_chunk == '0);
            end
            ST_FIN1: begin
                o_cmd.fin1 = 1'b1;
            end
            ST_FIN2: begin
                o_cmd.fin2 = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == ST_MAP))
        else $error("joint evaluation did not start");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (o_cmd.op == pje_pkg::MOP_NONE))
        else $error("store load during evaluation");

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN2 && !i_status.out_free) |=> (r_state == ST_FIN2))
        else $error("result dropped while output busy");

endmodule

[hw/rtl/pje_datapath.sv]
// ----------------------------------------------------------------------------
// pje_datapath
// vector stores, shared multiplier with accumulators, totals and output register
// ----------------------------------------------------------------------------
module pje_datapath #(
    parameter int COORD_WIDTH = pje_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = pje_pkg::FRAC_BITS_DEF,
    parameter int DATA_W      = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pje_pkg::t_cmd     i_cmd,
    output pje_pkg::t_status  o_status,
    input  logic [DATA_W-1:0] i_s_axis_tdata,
    input  logic [4:0]        i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [127:0]      o_m_axis_tdata,
    output logic [0:0]        o_m_axis_tuser,
    output logic              o_m_axis_tlast
);

    localparam int CW  = COORD_WIDTH;
    localparam int MW  = CW + 2;
    localparam int AW  = 2 * CW + 6;
    localparam int SQW = 2 * CW + 4;
    localparam int CHW = CW + 1;
    localparam int NCH = (SQW + CW) / CHW;
    localparam int HW  = 3 * CW + 4;
    localparam int HSH = 3 * FRAC_BITS + 1;
    localparam logic signed [AW-1:0] SMAX = {{(AW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
    localparam logic signed [AW-1:0] SMIN = ~SMAX;

    // stores
    logic signed [CW-1:0] r_fa [12];
    logic signed [CW-1:0] r_fb [12];
    logic signed [CW-1:0] r_anc [6];
    logic signed [CW-1:0] r_axis [3];
    logic signed [CW-1:0] r_kpos;
    logic signed [CW-1:0] r_krot;

    // intermediates
    logic signed [CW-1:0]   r_pa [3];
    logic signed [CW-1:0]   r_pb [3];
    logic signed [CW-1:0]   r_proj;
    logic signed [CW+1:0]   r_res [3];
    logic [SQW-1:0]         r_sqpos;
    logic [SQW-1:0]         r_sqrot;
    logic [62:0]            r_hpos;
    logic [62:0]            r_hrot;
    logic [62:0]            r_e;
    logic [62:0]            r_total;
    logic                   r_sat;
    logic                   r_batch;

    logic signed [2*MW-1:0] r_prod;
    pje_pkg::t_cmd          r_cmd1;
    logic signed [AW-1:0]   r_acc;
    logic [HW-1:0]          r_hacc;

    logic                   r_out_valid;
    logic [62:0]            r_out_je;
    logic [62:0]            r_out_tot;
    logic                   r_out_batch;
    logic                   r_out_sat;

    logic [3:0]             slot;
    logic signed [CW-1:0]   in_vec [3];
    logic [3:0]             rd_idx;
    logic [2:0]             anc_idx;
    logic signed [CW-1:0]   fa_rd, fb_rd, frm_rd, anc_rd, axis_rd;
    logic signed [CW:0]     d_rd, d_st2, rowdiff;
    logic signed [CW-1:0]   keff;
    logic [NCH*CHW-1:0]     sq_ext;
    logic [CHW-1:0]         chunk;
    logic signed [MW-1:0]   mul_a, mul_b;

    logic signed [AW-1:0]   acc_next;
    logic [HW-1:0]          hacc_next;
    logic [CW:0]            cl;
    logic [63:0]            hc;
    logic [63:0]            e_sum;
    logic [63:0]            tot_sum;

    // floor shift to the coordinate format, clamped; msb is the clip flag
    function automatic logic [CW:0] clamp_q(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] s;
        s = v >>> FRAC_BITS;
        if (s > SMAX) begin
            clamp_q = {1'b1, SMAX[CW-1:0]};
        end else if (s < SMIN) begin
            clamp_q = {1'b1, SMIN[CW-1:0]};
        end else begin
            clamp_q = {1'b0, s[CW-1:0]};
        end
    endfunction

    // half of k*sq, moved to q31.32 and clamped; msb is the clip flag
    function automatic logic [63:0] half_conv(input logic [HW-1:0] v);
        logic [HW+31:0] w;
        w = {v, 32'b0} >> HSH;
        if (|w[HW+31:63]) begin
            half_conv = {1'b1, pje_pkg::MAX63};
        end else begin
            half_conv = {1'b0, w[62:0]};
        end
    endfunction

    assign slot      = i_s_axis_tuser[3:0];
    assign in_vec[0] = i_s_axis_tdata[CW-1:0];
    assign in_vec[1] = i_s_axis_tdata[2*CW-1:CW];
    assign in_vec[2] = i_s_axis_tdata[3*CW-1:2*CW];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            unique case (slot) inside
                [pje_pkg::SLOT_FRAME_A_FIRST:pje_pkg::SLOT_FRAME_A_LAST]: begin
                    for (int c = 0; c < 3; c++) r_fa[4'(slot[1:0] * 3 + c)] <= in_vec[c];
                end
                [pje_pkg::SLOT_FRAME_B_FIRST:pje_pkg::SLOT_FRAME_B_LAST]: begin
                    for (int c = 0; c < 3; c++) r_fb[4'(slot[1:0] * 3 + c)] <= in_vec[c];
                end
                pje_pkg::SLOT_ANCHOR_A, pje_pkg::SLOT_ANCHOR_B: begin
                    for (int c = 0; c < 3; c++) r_anc[3'(slot[0] * 3 + c)] <= in_vec[c];
                end
                pje_pkg::SLOT_AXIS: begin
                    for (int c = 0; c < 3; c++) r_axis[c] <= in_vec[c];
                end
                pje_pkg::SLOT_STIFF: begin
                    r_kpos <= in_vec[0];
                    r_krot <= in_vec[1];
                end
                default: begin
                end
            endcase
        end
    end

    // operand fetch for the current step
    always_comb begin
        rd_idx  = 4'(i_cmd.row * 3 + i_cmd.comp);
        anc_idx = 3'((i_cmd.body ? 3 : 0) + ((i_cmd.row == 2'd0) ? 0 : i_cmd.row - 2'd1));
        fa_rd   = r_fa[rd_idx];
        fb_rd   = r_fb[rd_idx];
        frm_rd  = i_cmd.body ? fb_rd : fa_rd;
        anc_rd  = r_anc[anc_idx];
        axis_rd = r_axis[i_cmd.comp];
        d_rd    = {r_pb[i_cmd.comp][CW-1], r_pb[i_cmd.comp]}
                - {r_pa[i_cmd.comp][CW-1], r_pa[i_cmd.comp]};
        rowdiff = {fa_rd[CW-1], fa_rd} - {fb_rd[CW-1], fb_rd};
        keff    = (i_cmd.op == pje_pkg::MOP_KPOS) ? r_kpos : r_krot;
        if (keff[CW-1]) keff = '0;
        sq_ext  = {{(NCH * CHW - SQW){1'b0}},
                   (i_cmd.op == pje_pkg::MOP_KPOS) ? r_sqpos : r_sqrot};
        chunk   = sq_ext[i_cmd.chunk * CHW +: CHW];

        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            pje_pkg::MOP_MAP: begin
                mul_a = {{2{frm_rd[CW-1]}}, frm_rd};
                if (i_cmd.row == 2'd0) begin
                    mul_b = {{(MW - 1){1'b0}}, 1'b1} << FRAC_BITS;
                end else begin
                    mul_b = {{2{anc_rd[CW-1]}}, anc_rd};
                end
            end
            pje_pkg::MOP_AXD: begin
                mul_a = {{2{axis_rd[CW-1]}}, axis_rd};
                mul_b = {d_rd[CW], d_rd};
            end
            pje_pkg::MOP_AXP: begin
                mul_a = {{2{axis_rd[CW-1]}}, axis_rd};
                mul_b = {{2{r_proj[CW-1]}}, r_proj};
            end
            pje_pkg::MOP_RSQ: begin
                mul_a = r_res[i_cmd.comp];
                mul_b = r_res[i_cmd.comp];
            end
            pje_pkg::MOP_DSQ: begin
                mul_a = {rowdiff[CW], rowdiff};
                mul_b = {rowdiff[CW], rowdiff};
            end
            pje_pkg::MOP_KPOS, pje_pkg::MOP_KROT: begin
                mul_a = {2'b00, keff};
                mul_b = {1'b0, chunk};
            end
            default: begin
            end
        endcase
    end

    // accumulate stage, behind the product and command registers
    always_comb begin
        acc_next  = r_cmd1.first ? AW'(r_prod) : r_acc + AW'(r_prod);
        hacc_next = r_cmd1.first ? HW'(r_prod[2*CW-1:0])
                                 : (r_hacc << CHW) + HW'(r_prod[2*CW-1:0]);
        cl        = clamp_q(acc_next);
        hc        = half_conv(hacc_next);
        d_st2     = {r_pb[r_cmd1.comp][CW-1], r_pb[r_cmd1.comp]}
                  - {r_pa[r_cmd1.comp][CW-1], r_pa[r_cmd1.comp]};
        e_sum     = {1'b0, r_hpos} + {1'b0, r_hrot};
        tot_sum   = {1'b0, r_total} + {1'b0, r_e};
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_cmd1 <= '0;
        end else begin
            r_cmd1 <= i_cmd;
        end

        if (r_cmd1.op != pje_pkg::MOP_NONE) begin
            r_acc  <= acc_next;
            r_hacc <= hacc_next;
        end

        if (r_cmd1.last) begin
            case (r_cmd1.op)
                pje_pkg::MOP_MAP: begin
                    if (r_cmd1.body) r_pb[r_cmd1.comp] <= cl[CW-1:0];
                    else r_pa[r_cmd1.comp] <= cl[CW-1:0];
                end
                pje_pkg::MOP_AXD: r_proj <= cl[CW-1:0];
                pje_pkg::MOP_AXP: begin
                    r_res[r_cmd1.comp] <= {d_st2[CW], d_st2}
                                        - {{2{cl[CW-1]}}, cl[CW-1:0]};
                end
                pje_pkg::MOP_RSQ:  r_sqpos <= acc_next[SQW-1:0];
                pje_pkg::MOP_DSQ:  r_sqrot <= acc_next[SQW-1:0];
                pje_pkg::MOP_KPOS: r_hpos  <= hc[62:0];
                pje_pkg::MOP_KROT: r_hrot  <= hc[62:0];
                default: begin
                end
            endcase
        end

        if (i_cmd.start) begin
            r_sat   <= 1'b0;
            r_batch <= i_s_axis_tuser[4];
        end else if (r_cmd1.last) begin
            case (r_cmd1.op)
                pje_pkg::MOP_MAP, pje_pkg::MOP_AXD, pje_pkg::MOP_AXP: begin
                    if (cl[CW]) r_sat <= 1'b1;
                end
                pje_pkg::MOP_KPOS, pje_pkg::MOP_KROT: begin
                    if (hc[63]) r_sat <= 1'b1;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.fin1 && e_sum[63]) begin
            r_sat <= 1'b1;
        end

        if (i_cmd.fin1) begin
            r_e <= e_sum[63] ? pje_pkg::MAX63 : e_sum[62:0];
        end

        if (i_cmd.fin2) begin
            r_out_je    <= r_e;
            r_out_tot   <= tot_sum[63] ? pje_pkg::MAX63 : tot_sum[62:0];
            r_out_batch <= r_batch;
            r_out_sat   <= r_sat | tot_sum[63];
        end

        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.fin2) begin
                r_total     <= r_batch ? '0
                             : (tot_sum[63] ? pje_pkg::MAX63 : tot_sum[62:0]);
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = {2'b00, r_out_tot, r_out_je};
    assign o_m_axis_tuser    = r_out_sat;
    assign o_m_axis_tlast    = r_out_batch;

    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin2 |=> r_out_valid)
        else $error("result not presented");

    a_batch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fin2 && r_batch) |=> (r_total == '0))
        else $error("total not cleared at batch end");

endmodule

[hw/rtl/prismatic_joint_energy_unit.sv]
// ----------------------------------------------------------------------------
// prismatic_joint_energy_unit
// penalty energy of a prismatic joint between two affine bodies, q16.16 in
// ----------------------------------------------------------------------------
// usage:
//   slave channel: one tagged vector per transaction; tuser carries the slot,
//   tlast marks the last vector of a joint and tuser[4] the end of a batch
//   vectors that do not end a joint are stored as they are accepted
//   a vector with tlast starts an evaluation on the shared multiplier: two
//   anchor maps (24 steps), axis projection (7), squares (12) and the two
//   stiffness products (6), then totals (3); every product goes through the
//   one multiply-accumulate unit; a joint carries twelve vectors, one per slot
//   tready stays low during the evaluation and rises once the result is loaded
//   master channel: energy and saturating batch total in tdata, tlast marks
//   the last result of a batch, tuser flags any clip in this evaluation
//   the result sits in an output register; the next vectors are accepted while
//   it waits; a following evaluation holds its result until the register frees
//   reset clears the batch total and the output valid; stores stay undefined
// ----------------------------------------------------------------------------
module prismatic_joint_energy_unit #(
    parameter int COORD_WIDTH = pje_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = pje_pkg::FRAC_BITS_DEF,
    parameter int DATA_W      = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // slave side
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [DATA_W-1:0] i_s_axis_tdata,  // vec_x, vec_y, vec_z, zero pad
    input  logic [4:0]        i_s_axis_tuser,  // slot[3:0], last_of_batch
    input  logic              i_s_axis_tlast,  // last_of_joint
    // master side
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [127:0]      o_m_axis_tdata,  // joint_energy, total_energy, zero pad
    output logic [0:0]        o_m_axis_tuser,  // saturated
    output logic              o_m_axis_tlast   // batch_done
);

    // command and status between sequencer and datapath
    pje_pkg::t_cmd    cmd;
    pje_pkg::t_status status;

    pje_ctrl #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    pje_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .DATA_W      (DATA_W)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
